// ===== design/assert_macros.svh =====
// Assertion macros shared by the button press classifier design files.
// Depends on nothing; users must provide aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, skipped while reset is held.
`define BPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checks that a condition in a cycle implies a consequence in the same cycle.
`define BPC_ASSERT_IMPL(label, ante, cons, msg) \
    `BPC_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== design/bpc_pkg.sv =====
// Shared types, constants and helper functions of the button press classifier.
// Depends on nothing; used by bpc_core and button_press_classifier.
package bpc_pkg;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int MASK_W  = 16;
    localparam int THR_W   = 16;
    localparam int COUNT_W = 16;
    localparam int CODE_W  = 3;
    localparam int TOP_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam int BUTTON_COUNT_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd2;

    // Configuration reset values.
    localparam logic [THR_W-1:0] SHORT_PRESS_RST   = 16'd50;
    localparam logic [THR_W-1:0] LONG_PRESS_RST    = 16'd1000;
    localparam logic [THR_W-1:0] REPEAT_PERIOD_RST = 16'd250;

    // Event codes carried in each result word.
    localparam logic [CODE_W-1:0] EV_NONE          = 3'd0;
    localparam logic [CODE_W-1:0] EV_SHORT_PRESS   = 3'd1;
    localparam logic [CODE_W-1:0] EV_SHORT_RELEASE = 3'd2;
    localparam logic [CODE_W-1:0] EV_LONG_PRESS    = 3'd3;
    localparam logic [CODE_W-1:0] EV_LONG_RELEASE  = 3'd4;
    localparam logic [CODE_W-1:0] EV_PULSE         = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [THR_W-1:0] short_press_ms;
        logic [THR_W-1:0] long_press_ms;
        logic [THR_W-1:0] repeat_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  idle_ms;
        logic [TIME_W-1:0]  held_ms;
        logic [COUNT_W-1:0] repeat_count;
        logic [TOP_W-1:0]   top_button;
        logic [MASK_W-1:0]  held_mask;
        logic [CODE_W-1:0]  press_state;
        logic [CODE_W-1:0]  event_code;
    } result_t;

    // One plus the index of the highest set bit, zero for an empty mask.
    function automatic logic [TOP_W-1:0] top_index(input logic [MASK_W-1:0] m);
        logic [TOP_W-1:0] n;
        n = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (m[i]) begin
                n = TOP_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== design/button_press_classifier.sv =====
// Top level of the button press classifier: stream ports, configuration
// registers, input and result registers. Depends on bpc_pkg and bpc_core.
`include "assert_macros.svh"

// The block takes one tick word per clock cycle while results are taken and returns
// exactly one result word per tick, in order. A tick is captured in the input
// register, with its elapsed time already formed, and is classified into the
// result register once that register is free; the result is registered there
// and presented on m_tdata with m_tvalid. While a result waits on m_tready
// the input register takes one more tick and then holds s_tready low until the
// result is taken; with m_tready high a tick is accepted every cycle, the rate
// being set by the state update in bpc_core, made once per processed tick. Configuration
// writes are taken in any cycle and must only be made while no tick is in flight.
module button_press_classifier #(
    parameter int BUTTON_COUNT = bpc_pkg::BUTTON_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Tick input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // now_ms, sampled_mask
    // Result output.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // event_code, press_state, held_mask, top_button, repeat_count,
    // held_ms, idle_ms, then zero padding
    output logic [111:0]                    m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::THR_W-1:0]       cfg_data
);

    localparam int MW        = bpc_pkg::MASK_W;
    localparam int TW        = bpc_pkg::TIME_W;
    localparam int MASK_BITS = (BUTTON_COUNT < MW) ? BUTTON_COUNT : MW;
    localparam logic [MW:0] ONE = (MW + 1)'(1);
    localparam logic [MW-1:0] BUTTON_MASK = MW'((ONE << MASK_BITS) - ONE);
    localparam int RES_W = $bits(bpc_pkg::result_t);

    bpc_pkg::cfg_t             cfg_reg;
    logic                      in_valid_reg;
    logic [TW-1:0]             in_delta_reg;
    logic [MW-1:0]             in_sample_reg;
    logic [TW-1:0]             last_now_reg;
    logic                      out_valid_reg;
    bpc_pkg::result_t          out_reg;
    bpc_pkg::result_t          res;
    logic                      advance;
    logic                      s_accept;

    // Handshake: the held tick moves on whenever the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_press_ms   <= bpc_pkg::SHORT_PRESS_RST;
            cfg_reg.long_press_ms    <= bpc_pkg::LONG_PRESS_RST;
            cfg_reg.repeat_period_ms <= bpc_pkg::REPEAT_PERIOD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                bpc_pkg::REG_SHORT_PRESS:   cfg_reg.short_press_ms   <= cfg_data;
                bpc_pkg::REG_LONG_PRESS:    cfg_reg.long_press_ms    <= cfg_data;
                bpc_pkg::REG_REPEAT_PERIOD: cfg_reg.repeat_period_ms <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control of the input and result registers, and the last tick time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_now_reg  <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
                last_now_reg <= s_tdata[TW-1:0];
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input word: elapsed time since the previous tick and the masked sample.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_delta_reg  <= s_tdata[TW-1:0] - last_now_reg;
            in_sample_reg <= s_tdata[TW+MW-1:TW] & BUTTON_MASK;
        end
    end

    bpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .delta   (in_delta_reg),
        .sample  (in_sample_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(112 - RES_W)'(0), out_reg};

    // Every processed tick leaves a result in the output register.
    `BPC_ASSERT(a_result_loaded, $past(advance) |-> out_valid_reg, "processed tick has no result")
    // A held tick only waits while the result register is stalled.
    `BPC_ASSERT_IMPL(a_wait_stall, in_valid_reg && !advance, !m_tready, "tick waits unstalled")

endmodule

// ===== design/bpc_core.sv =====
// Press state machine of the button press classifier: debounce, short and
// long press, auto-repeat and time accounting. Depends on bpc_pkg.
`include "assert_macros.svh"

module bpc_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic [bpc_pkg::TIME_W-1:0]   delta,
    input  logic [bpc_pkg::MASK_W-1:0]   sample,
    input  bpc_pkg::cfg_t                cfg,
    output bpc_pkg::result_t             res
);

    typedef enum logic [2:0] {
        PH_UP        = 3'd0,
        PH_BOUNCE    = 3'd1,
        PH_SHORT     = 3'd2,
        PH_SHORT_REL = 3'd3,
        PH_LONG      = 3'd4,
        PH_LONG_REL  = 3'd5,
        PH_PULSE     = 3'd6
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [bpc_pkg::MASK_W-1:0]    mask_reg, mask_next;
    logic [bpc_pkg::TIME_W-1:0]    held_reg, held_next;
    logic [bpc_pkg::TIME_W-1:0]    idle_reg, idle_next;
    logic [bpc_pkg::TIME_W-1:0]    target_reg, target_next;
    logic [bpc_pkg::COUNT_W-1:0]   pulses_reg, pulses_next;
    logic [bpc_pkg::CODE_W-1:0]    event_next;
    logic                          long_phase;
    logic                          pulse_step;

    // Next state for one tick.
    always_comb begin
        logic [bpc_pkg::TIME_W-1:0] held_acc;
        logic [bpc_pkg::TIME_W-1:0] rearm;
        phase_next  = phase_reg;
        mask_next   = mask_reg;
        held_next   = held_reg;
        idle_next   = idle_reg;
        target_next = target_reg;
        pulses_next = pulses_reg;
        event_next  = bpc_pkg::EV_NONE;

        // Elapsed time goes to the held or the idle total.
        held_acc = held_reg + delta;
        rearm    = held_acc + bpc_pkg::TIME_W'(cfg.repeat_period_ms);
        if (mask_reg != '0) begin
            held_next = held_acc;
        end else begin
            idle_next = idle_reg + delta;
        end

        // A release lasts one tick; a pulse falls back to long press.
        if (phase_reg == PH_SHORT_REL || phase_reg == PH_LONG_REL) begin
            mask_next   = '0;
            held_next   = '0;
            idle_next   = '0;
            pulses_next = '0;
            phase_next  = PH_UP;
        end else if (phase_reg == PH_PULSE) begin
            phase_next = PH_LONG;
        end

        case (phase_next)
            PH_UP: begin
                if (sample != '0) begin
                    held_next   = '0;
                    pulses_next = '0;
                    mask_next   = sample;
                    phase_next  = PH_BOUNCE;
                end
            end
            PH_BOUNCE: begin
                if (mask_reg != sample) begin
                    mask_next   = '0;
                    held_next   = '0;
                    idle_next   = '0;
                    pulses_next = '0;
                    phase_next  = PH_UP;
                end else if (held_acc >= bpc_pkg::TIME_W'(cfg.short_press_ms)) begin
                    phase_next = PH_SHORT;
                    event_next = bpc_pkg::EV_SHORT_PRESS;
                end
            end
            PH_SHORT: begin
                if (sample == '0) begin
                    phase_next = PH_SHORT_REL;
                    event_next = bpc_pkg::EV_SHORT_RELEASE;
                end else if (held_acc >= bpc_pkg::TIME_W'(cfg.long_press_ms)) begin
                    target_next = rearm;
                    phase_next  = PH_LONG;
                    event_next  = bpc_pkg::EV_LONG_PRESS;
                end
            end
            PH_LONG: begin
                if (sample == '0) begin
                    phase_next = PH_LONG_REL;
                    event_next = bpc_pkg::EV_LONG_RELEASE;
                end else if (held_acc >= target_reg) begin
                    target_next = rearm;
                    if (pulses_reg != bpc_pkg::COUNT_MAX) begin
                        pulses_next = pulses_reg + 1'b1;
                    end
                    phase_next = PH_PULSE;
                    event_next = bpc_pkg::EV_PULSE;
                end
            end
            default: begin
            end
        endcase
    end

    // State registers, updated once per processed tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_UP;
            mask_reg   <= '0;
            held_reg   <= '0;
            idle_reg   <= '0;
            target_reg <= '0;
            pulses_reg <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            mask_reg   <= mask_next;
            held_reg   <= held_next;
            idle_reg   <= idle_next;
            target_reg <= target_next;
            pulses_reg <= pulses_next;
        end
    end

    // Result word built from the updated state.
    always_comb begin
        res.event_code   = event_next;
        res.press_state  = bpc_pkg::CODE_W'(phase_next);
        res.held_mask    = mask_next;
        res.top_button   = bpc_pkg::top_index(mask_next);
        res.repeat_count = pulses_next;
        res.held_ms      = held_next;
        res.idle_ms      = idle_next;
    end

    // Terms used by the checks below.
    assign long_phase = (phase_reg == PH_LONG) || (phase_reg == PH_PULSE)
                        || (phase_reg == PH_LONG_REL);
    assign pulse_step = step_en && (event_next == bpc_pkg::EV_PULSE);

    // A mask is latched exactly when the block is not up.
    `BPC_ASSERT(a_mask_vs_phase, (phase_reg == PH_UP) == (mask_reg == '0), "mask and phase differ")
    // Repeat pulses are only counted once a press has gone long.
    `BPC_ASSERT_IMPL(a_pulses_long, pulses_reg != '0, long_phase, "pulse count outside long press")
    // A pulse event always leaves the block in the pulse phase.
    `BPC_ASSERT_IMPL(a_pulse_phase, pulse_step, phase_next == PH_PULSE, "stray pulse event")

endmodule
